// ----- hw/rtl/ppe_pkg.sv -----
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants for the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_REM  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ADDED  = 3'd0,
    K_FULL   = 3'd1,
    K_RECORD = 3'd2,
    K_DONE   = 3'd3,
    K_REMOVE = 3'd4
  } kind_t;

  localparam logic [1:0] CFG_GX = 2'd0;
  localparam logic [1:0] CFG_GY = 2'd1;
  localparam logic [1:0] CFG_GZ = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         slot;
    logic [9:0]         time_delta;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_vx;
    logic signed [31:0] start_vy;
    logic signed [31:0] start_vz;
    logic [15:0]        life_ms;
    logic [15:0]        frame_period;
    logic [8:0]         frame_total;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         out_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        life_left;
    logic [7:0]         frame_now;
    logic               last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_CALC,
    S_EMIT
  } st_t;

  // round(p/1000), ties away from zero, in two steps; |p| < 2^41
  // m = |p| + 500 = hi*2^21 + lo, and 2^21 = 2097*1000 + 152
  function automatic logic [31:0] d1000_hi(input logic signed [41:0] p);
    logic [41:0] m;
    m = (p[41] ? 42'(-p) : 42'(p)) + 42'd500;
    d1000_hi = 32'(m[41:21]) * 32'd2097;
  endfunction

  // leftover hi*152 + lo, below 2^29
  function automatic logic [28:0] d1000_rem(input logic signed [41:0] p);
    logic [41:0] m;
    m = (p[41] ? 42'(-p) : 42'(p)) + 42'd500;
    d1000_rem = 29'(m[41:21]) * 29'd152 + 29'(m[20:0]);
  endfunction

  // leftover / 1000 by reciprocal, exact for values below 2^29
  function automatic logic signed [33:0] d1000_join(input logic neg,
                                                    input logic [31:0] qh,
                                                    input logic [28:0] r1);
    logic [58:0] t;
    logic [33:0] q;
    t = 59'(r1) * 59'(30'd549755814);
    q = 34'(qh) + 34'(t[58:39]);
    d1000_join = neg ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ----- hw/rtl/particle_pool_engine.sv -----
// ----------------------------------------------------------------------------
// particle_pool_engine
// Particle slot pool with add, remove and per-slot tick update.
// ----------------------------------------------------------------------------
// Add scans slots from the free hint; remove clears one slot.
// Tick sweeps the slots; each live slot gets a slot read, two multiply
// and two-step divide passes, then write back and report.
// One item is worked at a time; a two-word input queue accepts until full.
// Synchronous active-low reset: all slots dead, free hint 0, gravity 0.
module particle_pool_engine import ppe_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic signed [31:0] gx_r, gy_r, gz_r;
  logic q_valid, q_take;
  in_word_t q_data;

  // gravity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= '0; gy_r <= '0; gz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GX: gx_r <= cfg_wdata;
        CFG_GY: gy_r <= cfg_wdata;
        CFG_GZ: gz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppe_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_data, .q_take
  );

  ppe_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take,
    .grav_x(gx_r), .grav_y(gy_r), .grav_z(gz_r),
    .out_valid, .out_stall, .out_data
  );

endmodule

// ----- hw/rtl/ppe_front.sv -----
// ----------------------------------------------------------------------------
// ppe_front
// Input side: takes words and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module ppe_front import ppe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     q_valid,
  output in_word_t q_data,
  input  logic     q_take
);

  in_word_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic push;

  assign in_stall = (cnt_r == 2'd2);
  // unknown ops are dropped here
  assign push = in_valid && !in_stall && (in_data.op != OP_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rd_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_take && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (q_take && q_valid) rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= in_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue overflow");
  a_take: assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
    else $error("take from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_take) |=> cnt_r == 2'd2)
    else $error("full queue lost a word");

endmodule

// ----- hw/rtl/ppe_back.sv -----
// ----------------------------------------------------------------------------
// ppe_back
// Slot store and sequencer: add scan, remove, tick sweep over all slots.
// ----------------------------------------------------------------------------
module ppe_back import ppe_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  in_word_t           q_data,
  output logic               q_take,
  input  logic signed [31:0] grav_x,
  input  logic signed [31:0] grav_y,
  input  logic signed [31:0] grav_z,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] TERM = AW'(CAPACITY - 1);
  localparam logic [5:0] SLOT_TERM = 6'(CAPACITY - 1);

  // live flag per slot in flops; life and payload in memories
  logic [CAPACITY-1:0] live_r;
  logic [15:0] life_m [CAPACITY];
  logic [31:0] px_m [CAPACITY];
  logic [31:0] py_m [CAPACITY];
  logic [31:0] pz_m [CAPACITY];
  logic [31:0] vx_m [CAPACITY];
  logic [31:0] vy_m [CAPACITY];
  logic [31:0] vz_m [CAPACITY];
  logic [16:0] ft_m [CAPACITY];
  logic [7:0]  fi_m [CAPACITY];
  logic [24:0] fs_m [CAPACITY];

  st_t st_r, st_nxt;
  logic [AW-1:0] hint_r, idx_r;
  in_word_t cmd_r;
  logic [2:0] phase_r;
  logic signed [31:0] rv_r [3];
  logic signed [31:0] rp_r [3];
  logic signed [31:0] nv_r [3];
  logic signed [41:0] pr_r [3];
  logic               sn_r [3];
  logic [31:0]        sh_r [3];
  logic [28:0]        sr_r [3];
  logic signed [33:0] dq_r [3];
  logic [15:0] rlife_r;
  logic [16:0] rft_r;
  logic [7:0]  rfi_r;
  logic [24:0] rfs_r;
  out_word_t ob_r;
  logic ov_r;
  logic ov_set;
  logic obuf_free;
  logic live;
  logic signed [16:0] life_nx;
  logic keep;
  logic signed [31:0] g [3];

  assign g[0] = grav_x;
  assign g[1] = grav_y;
  assign g[2] = grav_z;
  assign obuf_free = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data = ob_r;
  assign q_take = (st_r == S_IDLE) && q_valid && obuf_free;
  assign live = live_r[idx_r];
  assign life_nx = $signed({1'b0, rlife_r} - {7'd0, cmd_r.time_delta});
  assign keep = !life_nx[16] && (life_nx != 17'sd0);

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -34'sd2147483648) sat = 32'sh80000000;
    else sat = 32'(v);
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_take) begin
        if (q_data.op == OP_ADD) st_nxt = S_SCAN;
        else if (q_data.op == OP_TICK) st_nxt = S_TICK;
      end
      S_SCAN: if (obuf_free && (idx_r >= TERM || !live)) st_nxt = S_IDLE;
      S_TICK: if (obuf_free) begin
        if (idx_r >= TERM) st_nxt = S_IDLE;
        else if (live) st_nxt = S_CALC;
      end
      S_CALC: if (phase_r == 3'd7) st_nxt = S_EMIT;
      S_EMIT: if (obuf_free) st_nxt = S_TICK;
      default: st_nxt = S_IDLE;
    endcase
  end

  // new result word loaded into the output register
  always_comb begin
    case (st_r)
      S_IDLE:  ov_set = q_take && (q_data.op == OP_REM);
      S_SCAN:  ov_set = obuf_free && (idx_r >= TERM || !live);
      S_TICK:  ov_set = obuf_free && (idx_r >= TERM);
      S_EMIT:  ov_set = obuf_free && keep;
      default: ov_set = 1'b0;
    endcase
  end

  // control and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      hint_r  <= '0;
      ov_r    <= 1'b0;
      phase_r <= '0;
      live_r  <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_set || (ov_r && out_stall);
      case (st_r)
        S_IDLE: begin
          phase_r <= '0;
          if (q_take && q_data.op == OP_REM && q_data.slot < SLOT_TERM) begin
            live_r[q_data.slot[AW-1:0]] <= 1'b0;
            if (q_data.slot[AW-1:0] < hint_r) hint_r <= q_data.slot[AW-1:0];
          end
        end
        S_SCAN: if (obuf_free) begin
          if (idx_r >= TERM) begin
            hint_r <= TERM;
          end else if (!live) begin
            live_r[idx_r] <= (cmd_r.life_ms != 16'd0);
            hint_r <= idx_r + AW'(1);
          end
        end
        S_TICK: phase_r <= '0;
        S_CALC: phase_r <= phase_r + 3'd1;
        S_EMIT: if (obuf_free && !keep) begin
          live_r[idx_r] <= 1'b0;
          if (idx_r < hint_r) hint_r <= idx_r;
        end
        default: ;
      endcase
    end
  end

  // datapath: index, command, arithmetic pipeline, stores, output word
  always_ff @(posedge clk) begin
    out_word_t   ow;
    logic [8:0]  tot;
    logic [16:0] tm;
    logic [8:0]  f;
    logic [7:0]  fo;
    ow = ob_r;
    // frame timer and index step for the slot in flight
    tot = (rfs_r[8:0] > 9'd256) ? 9'd256 : rfs_r[8:0];
    tm = rft_r;
    fo = rfi_r;
    f = {1'b0, rfi_r} + 9'd1;
    if (rfs_r[24:9] != 16'd0) begin
      tm = rft_r + 17'(cmd_r.time_delta);
      if (tm > {1'b0, rfs_r[24:9]}) begin
        tm = '0;
        fo = (f >= tot) ? 8'd0 : f[7:0];
      end
    end
    case (st_r)
      S_IDLE: if (q_take) begin
        cmd_r <= q_data;
        idx_r <= (q_data.op == OP_ADD) ? hint_r : '0;
        ow = '0;
        ow.kind = K_REMOVE;
        ow.out_slot = q_data.slot;
        ow.last = 1'b1;
      end
      S_SCAN: if (obuf_free) begin
        if (idx_r >= TERM) begin
          ow = '0;
          ow.kind = K_FULL;
          ow.last = 1'b1;
        end else if (!live) begin
          ow = '0;
          ow.kind = K_ADDED;
          ow.out_slot = 6'(idx_r);
          ow.last = 1'b1;
          life_m[idx_r] <= cmd_r.life_ms;
          px_m[idx_r] <= cmd_r.start_x;
          py_m[idx_r] <= cmd_r.start_y;
          pz_m[idx_r] <= cmd_r.start_z;
          vx_m[idx_r] <= cmd_r.start_vx;
          vy_m[idx_r] <= cmd_r.start_vy;
          vz_m[idx_r] <= cmd_r.start_vz;
          ft_m[idx_r] <= '0;
          fi_m[idx_r] <= '0;
          fs_m[idx_r] <= {cmd_r.frame_period, cmd_r.frame_total};
        end else idx_r <= idx_r + AW'(1);
      end
      S_TICK: if (obuf_free) begin
        if (idx_r >= TERM) begin
          ow = '0;
          ow.kind = K_DONE;
          ow.last = 1'b1;
        end else if (!live) idx_r <= idx_r + AW'(1);
      end
      S_CALC: begin
        case (phase_r)
          // read slot, gravity step product
          3'd0: begin
            rv_r[0] <= vx_m[idx_r]; rv_r[1] <= vy_m[idx_r]; rv_r[2] <= vz_m[idx_r];
            rp_r[0] <= px_m[idx_r]; rp_r[1] <= py_m[idx_r]; rp_r[2] <= pz_m[idx_r];
            rft_r <= ft_m[idx_r]; rfi_r <= fi_m[idx_r]; rfs_r <= fs_m[idx_r];
            rlife_r <= life_m[idx_r];
            for (int a = 0; a < 3; a++)
              pr_r[a] <= 42'(g[a]) * $signed({1'b0, cmd_r.time_delta});
          end
          // divide by 1000, split
          3'd1, 3'd5: for (int a = 0; a < 3; a++) begin
            sn_r[a] <= pr_r[a][41];
            sh_r[a] <= d1000_hi(pr_r[a]);
            sr_r[a] <= d1000_rem(pr_r[a]);
          end
          // divide by 1000, join
          3'd2, 3'd6: for (int a = 0; a < 3; a++)
            dq_r[a] <= d1000_join(sn_r[a], sh_r[a], sr_r[a]);
          // new velocity
          3'd3: for (int a = 0; a < 3; a++)
            nv_r[a] <= sat(34'(rv_r[a]) + dq_r[a]);
          3'd4: for (int a = 0; a < 3; a++)
            pr_r[a] <= 42'(nv_r[a]) * $signed({1'b0, cmd_r.time_delta});
          // new position
          3'd7: for (int a = 0; a < 3; a++)
            rp_r[a] <= sat(34'(rp_r[a]) + dq_r[a]);
          default: ;
        endcase
      end
      S_EMIT: if (obuf_free) begin
        vx_m[idx_r] <= nv_r[0]; vy_m[idx_r] <= nv_r[1]; vz_m[idx_r] <= nv_r[2];
        px_m[idx_r] <= rp_r[0]; py_m[idx_r] <= rp_r[1]; pz_m[idx_r] <= rp_r[2];
        ft_m[idx_r] <= tm;
        fi_m[idx_r] <= fo;
        if (keep) life_m[idx_r] <= life_nx[15:0];
        ow.kind = K_RECORD;
        ow.out_slot = 6'(idx_r);
        ow.pos_x = rp_r[0];
        ow.pos_y = rp_r[1];
        ow.pos_z = rp_r[2];
        ow.life_left = life_nx[15:0];
        ow.frame_now = fo;
        ow.last = 1'b0;
        idx_r <= idx_r + AW'(1);
      end
      default: ;
    endcase
    ob_r <= ow;
  end

  a_hint: assert property (@(posedge clk) disable iff (!rst_n) hint_r <= TERM)
    else $error("free hint past terminator");
  a_term: assert property (@(posedge clk) disable iff (!rst_n) !live_r[TERM])
    else $error("terminator slot holds a particle");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CALC && phase_r == 3'd7) |=> st_r == S_EMIT)
    else $error("update pipeline skipped emit");

endmodule

// ----- sim/particle_pool_engine_test.sv -----
// ----------------------------------------------------------------------------
// particle_pool_engine_test
// Drives adds, removes and ticks into the particle pool with random idling on
// both sides and checks every result word against an in-bench pool model.
// ----------------------------------------------------------------------------
module particle_pool_engine_test;
  import ppe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = CAPACITY_DEF;
  localparam int unsigned TERM = SLOTS - 1;

  // pool model and expected result words
  class pool_board;
    logic signed [31:0] grav [3];
    int                 life [SLOTS];
    logic signed [31:0] pos [SLOTS][3];
    logic signed [31:0] vel [SLOTS][3];
    int unsigned        ftimer [SLOTS];
    int unsigned        fidx [SLOTS];
    int unsigned        fper [SLOTS];
    int unsigned        ftot [SLOTS];
    int unsigned        hint;
    out_word_t          pending [$];
    int                 errors;

    function new();
      for (int i = 0; i < 3; i++) grav[i] = 0;
      for (int s = 0; s < SLOTS; s++) life[s] = 0;
      hint = 0;
      errors = 0;
    endfunction

    // round(x*dt/1000), ties away from zero
    function longint scale(longint x, longint dt);
      longint p;
      p = x * dt;
      return (p >= 0) ? (p + 500) / 1000 : (p - 500) / 1000;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void kill(int unsigned s);
      life[s] = 0;
      if (s < hint) hint = s;
    endfunction

    function void push(kind_t k, int unsigned s, logic signed [31:0] px,
                       logic signed [31:0] py, logic signed [31:0] pz,
                       int unsigned lf, int unsigned fr, bit lst);
      out_word_t w;
      w.kind = k; w.out_slot = 6'(s); w.pos_x = px; w.pos_y = py; w.pos_z = pz;
      w.life_left = 16'(lf); w.frame_now = 8'(fr); w.last = lst;
      pending.push_back(w);
    endfunction

    // note an accepted input word
    function void note_input(in_word_t w);
      int unsigned h;
      longint v;
      longint dt;
      int unsigned f;
      dt = w.time_delta;
      case (w.op)
        OP_ADD: begin
          h = hint;
          while (h < TERM && life[h] > 0) h++;
          if (h >= TERM) begin
            hint = TERM;
            push(K_FULL, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            pos[h][0] = w.start_x; pos[h][1] = w.start_y; pos[h][2] = w.start_z;
            vel[h][0] = w.start_vx; vel[h][1] = w.start_vy; vel[h][2] = w.start_vz;
            life[h] = w.life_ms;
            fper[h] = w.frame_period;
            ftot[h] = w.frame_total;
            ftimer[h] = 0;
            fidx[h] = 0;
            hint = h + 1;
            push(K_ADDED, h, 0, 0, 0, 0, 0, 1);
          end
        end
        OP_REM: begin
          if (w.slot < TERM) kill(w.slot);
          push(K_REMOVE, w.slot, 0, 0, 0, 0, 0, 1);
        end
        OP_TICK: begin
          for (int unsigned s = 0; s < TERM; s++) begin
            if (life[s] <= 0) continue;
            for (int a = 0; a < 3; a++) begin
              v = sat(longint'(vel[s][a]) + scale(longint'(grav[a]), dt));
              vel[s][a] = 32'(v);
              pos[s][a] = 32'(sat(longint'(pos[s][a]) + scale(v, dt)));
            end
            life[s] -= int'(dt);
            if (fper[s] != 0) begin
              ftimer[s] = ftimer[s] + 32'(dt);
              if (ftimer[s] > fper[s]) begin
                f = (fidx[s] & 8'hff) + 1;
                ftimer[s] = 0;
                if (f >= ((ftot[s] > 256) ? 256 : ftot[s])) f = 0;
                fidx[s] = f;
              end
            end
            if (life[s] < 1) begin
              kill(s);
              continue;
            end
            push(K_RECORD, s, pos[s][0], pos[s][1], pos[s][2], life[s], fidx[s], 0);
          end
          push(K_DONE, 0, 0, 0, 0, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d slot %0d pos %h %h %h life %0d fr %0d last %0b",
                   exp_w.kind, exp_w.out_slot, exp_w.pos_x, exp_w.pos_y, exp_w.pos_z,
                   exp_w.life_left, exp_w.frame_now, exp_w.last,
                   "\n          got kind %0d slot %0d pos %h %h %h life %0d fr %0d last %0b",
                   got.kind, got.out_slot, got.pos_x, got.pos_y, got.pos_z,
                   got.life_left, got.frame_now, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_GX;
  logic [31:0] cfg_wdata = '0;

  pool_board board = new();
  bit        calm = 1'b0;

  particle_pool_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, check on accept
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // one input word, with a random idle gap first; valid stays up afterwards
  task automatic send_word(in_word_t w);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(w);
  endtask

  // write enable stays up; the caller drops it after the last write
  task automatic write_grav(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.grav[idx] = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] mild_q();
    return 32'($signed($urandom_range(200000))) - 32'sd100000 << $urandom_range(6);
  endfunction

  function automatic in_word_t add_word(bit wild);
    in_word_t w;
    w = '0;
    w.op = OP_ADD;
    w.slot = 6'($urandom);
    w.time_delta = 10'($urandom);
    w.start_x = wild ? rnd_q() : mild_q();
    w.start_y = wild ? rnd_q() : mild_q();
    w.start_z = wild ? rnd_q() : mild_q();
    w.start_vx = wild ? rnd_q() : mild_q();
    w.start_vy = wild ? rnd_q() : mild_q();
    w.start_vz = wild ? rnd_q() : mild_q();
    w.life_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    w.frame_period = ($urandom_range(3) == 0) ? 16'd0 :
                     ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200));
    w.frame_total = ($urandom_range(5) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8));
    return w;
  endfunction

  function automatic in_word_t tick_word(int unsigned dt);
    in_word_t w;
    w = add_word(1'b1);
    w.op = OP_TICK;
    w.time_delta = 10'(dt);
    return w;
  endfunction

  function automatic in_word_t rem_word(int unsigned s);
    in_word_t w;
    w = add_word(1'b1);
    w.op = OP_REM;
    w.slot = 6'(s);
    return w;
  endfunction

  initial begin
    in_word_t w;
    int unsigned r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero life, frame wrap, bad remove, unknown op
    write_grav(CFG_GX, 32'h8000_0000);
    write_grav(CFG_GY, 32'h7fff_ffff);
    write_grav(CFG_GZ, 32'h0001_0000);
    cfg_we <= 1'b0;
    w = add_word(1'b1);
    w.start_x = 32'h7fff_ffff; w.start_vx = 32'h7fff_ffff;
    w.start_y = 32'h8000_0000; w.start_vy = 32'h8000_0000;
    w.life_ms = 16'hffff; w.frame_period = 16'hffff; w.frame_total = 9'h1ff;
    send_word(w);
    w = add_word(1'b0); w.life_ms = 0; send_word(w);
    w = add_word(1'b0); w.life_ms = 500; w.frame_period = 1; w.frame_total = 0;
    send_word(w);
    w = add_word(1'b0); w.life_ms = 2000; w.frame_period = 1; w.frame_total = 2;
    send_word(w);
    send_word(tick_word(1000));
    send_word(tick_word(0));
    send_word(tick_word(10'h3ff));
    send_word(rem_word(63));
    send_word(rem_word(62));
    send_word(rem_word(0));
    w = add_word(1'b1); w.op = OP_NONE; send_word(w);
    send_word(tick_word(1));
    drain();

    // fill the pool to reach the full answer
    write_grav(CFG_GX, 32'hffff_0000);
    write_grav(CFG_GY, 32'h0000_0000);
    write_grav(CFG_GZ, 32'hfff6_0000);
    cfg_we <= 1'b0;
    repeat (TERM + 2) begin
      w = add_word(1'b0); w.life_ms = 16'd60000 + 16'($urandom_range(5000));
      send_word(w);
    end
    send_word(tick_word(500));
    send_word(rem_word(5));
    send_word(rem_word(40));
    w = add_word(1'b0); send_word(w);
    drain();

    // random mix: mostly adds and short ticks, some removes and noise
    for (int i = 0; i < 120; i++) begin
      calm = (i >= 40 && i < 70);
      if (i == 60) begin
        drain();
        write_grav(CFG_GX, mild_q());
        write_grav(CFG_GY, rnd_q());
        write_grav(CFG_GZ, $urandom);
        cfg_we <= 1'b0;
      end
      r = $urandom_range(99);
      if (r < 45) send_word(add_word($urandom_range(4) == 0));
      else if (r < 65) send_word(tick_word(($urandom_range(5) == 0) ?
                                           $urandom : $urandom_range(300)));
      else if (r < 92) send_word(rem_word(($urandom_range(7) == 0) ?
                                          $urandom : $urandom_range(20)));
      else begin
        w = add_word(1'b1); w.op = OP_NONE; send_word(w);
      end
    end
    calm = 1'b0;
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
